>>> hw/rtl/cwbd_pkg.sv
// ----------------------------------------------------------------------------
// cwbd_pkg
// Shared widths, register codes, result types and saturating add for the
// center window box downsampler.
// ----------------------------------------------------------------------------
package cwbd_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 18;
  localparam int SCALE_W    = 7;
  localparam int DIM_W      = 9;
  localparam int ROW_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SUM_W-1:0]   SUM_MAX        = 18'h3FFFF;
  localparam logic [SCALE_W-1:0] SCALE_MASK     = 7'h7C;
  localparam logic [SCALE_W-1:0] MIN_SCALE      = 7'd4;
  localparam logic [DIM_W-1:0]   MAX_OUT_HEIGHT = 9'd256;
  localparam logic [DIM_W-1:0]   RST_OUT_DIM    = 9'd64;
  localparam logic [SCALE_W-1:0] RST_SCALE      = 7'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 2'd2;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pix_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    pix_flags_t       flags;
  } pix_item_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

>>> hw/rtl/cwbd_colmem.sv
// ----------------------------------------------------------------------------
// cwbd_colmem
// Column sum memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cwbd_colmem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 18
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/cwbd_div.sv
// ----------------------------------------------------------------------------
// cwbd_div
// Restoring divider for the window mean, one quotient bit per cycle, with
// saturation of the mean at 255; emits 255 minus the mean.
// ----------------------------------------------------------------------------
module cwbd_div #(
  parameter int DIVW = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cwbd_pkg::SUM_W-1:0] sum_i,
  input  logic [DIVW-1:0]          divisor_i,
  input  cwbd_pkg::pix_flags_t     flags_i,
  output logic                     busy_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cwbd_pkg::pix_item_t      item_o
);

  localparam int CMPW = (DIVW + 8 > cwbd_pkg::SUM_W) ? DIVW + 8 : cwbd_pkg::SUM_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [cwbd_pkg::SUM_W-1:0]   rem_q, rem_d;
  logic [7:0]                   quo_q, quo_d;
  logic [2:0]                   bit_q, bit_d;
  logic [DIVW-1:0]              dvs_q, dvs_d;
  cwbd_pkg::pix_flags_t         flags_q, flags_d;
  logic [CMPW-1:0]              trial;
  logic                         sat;

  assign trial = CMPW'(dvs_q) << bit_q;
  assign sat   = CMPW'(sum_i) >= (CMPW'(divisor_i) << 8);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    dvs_d   = dvs_q;
    flags_d = flags_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          dvs_d   = divisor_i;
          flags_d = flags_i;
          rem_d   = sum_i;
          bit_d   = 3'd7;
          if (sat) begin
            quo_d   = 8'hFF;
            state_d = ST_DONE;
          end else begin
            quo_d   = 8'h00;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (CMPW'(rem_q) >= trial) begin
          rem_d        = rem_q - trial[cwbd_pkg::SUM_W-1:0];
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == 3'd0) begin
          state_d = ST_DONE;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      ST_DONE: begin
        if (ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
    dvs_q   <= dvs_d;
    flags_q <= flags_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = (state_q == ST_DONE);
  assign item_o.pixel = ~quo_q;
  assign item_o.flags = flags_q;

endmodule

>>> hw/rtl/center_window_box_downsampler.sv
// ----------------------------------------------------------------------------
// center_window_box_downsampler
// Sums the central window of each square source block through a per-column
// sum memory and emits 255 minus the window mean per block.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] green
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata pixel, tlast row_end,
//                                              tuser frame_end
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
//  one source pixel per cycle while no block mean is being divided
//  a block's last pixel stalls the input for the load, 8 quotient bits and
//  hand-off to the output, no bits if the mean saturates, longer if full
//  column sums read at block row segment ends, window rows written next cycle
//  reset clears counters and sets the registers to 8, 64, 64; no clear pass
//  the output register holds a result while the next pixels flow in
// ----------------------------------------------------------------------------
module center_window_box_downsampler #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int MAX_SCALE     = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] green
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] pixel
  output logic                              m_axis_tlast,  // row_end
  output logic                              m_axis_tuser,  // [0] frame_end
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cwbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cwbd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int SW   = cwbd_pkg::SCALE_W;
  localparam int CW   = $clog2(MAX_SCALE);
  localparam int XW   = (CW > SW) ? CW : SW;
  localparam int AW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int WLOG = $clog2(MAX_OUT_WIDTH + 1);
  localparam int WXW  = (WLOG > cwbd_pkg::DIM_W) ? WLOG : cwbd_pkg::DIM_W;
  localparam int HALF = MAX_SCALE / 2;
  localparam int DIVW = $clog2(HALF * HALF + 1);
  localparam int RW   = cwbd_pkg::ROW_W;
  localparam int DW   = cwbd_pkg::DIM_W;
  localparam int SUMW = cwbd_pkg::SUM_W;

  // configuration
  logic [SW-1:0] scale_cfg_q;
  logic [DW-1:0] width_cfg_q;
  logic [DW-1:0] height_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_cfg_q  <= cwbd_pkg::RST_SCALE;
      width_cfg_q  <= cwbd_pkg::RST_OUT_DIM;
      height_cfg_q <= cwbd_pkg::RST_OUT_DIM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cwbd_pkg::CFG_DISPLAY_SCALE: scale_cfg_q  <= cfg_data_i[SW-1:0];
        cwbd_pkg::CFG_OUT_WIDTH:     width_cfg_q  <= cfg_data_i;
        cwbd_pkg::CFG_OUT_HEIGHT:    height_cfg_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // effective geometry
  logic [SW-1:0]  scale;
  logic [SW-1:0]  quarter;
  logic [SW-1:0]  win_hi;
  logic [SW-1:0]  blk_last;
  logic [WXW-1:0] width_eff;
  logic [DW-1:0]  height_eff;
  logic [DIVW-1:0] divisor;
  logic [2*(SW-1)-1:0] half_sq;

  always_comb begin
    scale = scale_cfg_q & cwbd_pkg::SCALE_MASK;
    if (scale < cwbd_pkg::MIN_SCALE) begin
      scale = cwbd_pkg::MIN_SCALE;
    end
    if (32'(scale) > MAX_SCALE) begin
      scale = SW'(MAX_SCALE);
    end
  end

  assign quarter  = scale >> 2;
  assign win_hi   = scale - quarter;
  assign blk_last = scale - SW'(1);
  assign half_sq  = scale[SW-1:1] * scale[SW-1:1];
  assign divisor  = DIVW'(half_sq);

  always_comb begin
    if (width_cfg_q == '0) begin
      width_eff = WXW'(1);
    end else if (WXW'(width_cfg_q) > WXW'(MAX_OUT_WIDTH)) begin
      width_eff = WXW'(MAX_OUT_WIDTH);
    end else begin
      width_eff = WXW'(width_cfg_q);
    end
    if (height_cfg_q == '0) begin
      height_eff = DW'(1);
    end else if (height_cfg_q > cwbd_pkg::MAX_OUT_HEIGHT) begin
      height_eff = cwbd_pkg::MAX_OUT_HEIGHT;
    end else begin
      height_eff = height_cfg_q;
    end
  end

  // position counters and running row segment sum
  logic [CW-1:0]   col_q, col_d;
  logic [CW-1:0]   row_q, row_d;
  logic [AW-1:0]   bcol_q, bcol_d;
  logic [RW-1:0]   brow_q, brow_d;
  logic [SUMW-1:0] part_q, part_d;
  logic [SUMW-1:0] part_acc;
  logic [AW-1:0]   bc_addr;

  logic in_acc, row_in, col_in, bx_end, by_end, last_col, last_row;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign row_in   = (XW'(row_q) >= XW'(quarter)) && (XW'(row_q) < XW'(win_hi));
  assign col_in   = (XW'(col_q) >= XW'(quarter)) && (XW'(col_q) < XW'(win_hi));
  assign bx_end   = XW'(col_q) >= XW'(blk_last);
  assign by_end   = XW'(row_q) >= XW'(blk_last);
  assign last_col = WXW'(bcol_q) >= (width_eff - WXW'(1));
  assign last_row = DW'(brow_q) >= (height_eff - DW'(1));
  assign part_acc = (row_in && col_in)
                  ? cwbd_pkg::sat_add(part_q, SUMW'(s_axis_tdata)) : part_q;
  assign bc_addr  = (32'(bcol_q) > MAX_OUT_WIDTH - 1) ? AW'(MAX_OUT_WIDTH - 1) : bcol_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    part_d = part_q;
    if (in_acc) begin
      part_d = part_acc;
      if (bx_end) begin
        part_d = '0;
        col_d  = '0;
        if (last_col) begin
          bcol_d = '0;
          if (by_end) begin
            row_d  = '0;
            brow_d = last_row ? '0 : brow_q + RW'(1);
          end else begin
            row_d = row_q + CW'(1);
          end
        end else begin
          bcol_d = bcol_q + AW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
      part_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      part_q <= part_d;
    end
  end

  // write-back stage: memory data arrives in the cycle after the block end
  logic                 s1_valid_q;
  logic                 s1_wr_q;
  logic                 s1_first_q;
  logic                 s1_out_q;
  logic [AW-1:0]        s1_addr_q;
  logic [SUMW-1:0]      s1_part_q;
  cwbd_pkg::pix_flags_t s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && bx_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && bx_end) begin
      s1_wr_q              <= row_in;
      s1_first_q           <= (XW'(row_q) == XW'(quarter));
      s1_out_q             <= by_end;
      s1_addr_q            <= bc_addr;
      s1_part_q            <= part_acc;
      s1_flags_q.row_end   <= last_col;
      s1_flags_q.frame_end <= last_col && last_row;
    end
  end

  logic [SUMW-1:0] rd_data;
  logic [SUMW-1:0] col_new;
  logic            mem_rd_en;
  logic            mem_wr_en;

  assign mem_rd_en = in_acc && bx_end;
  assign mem_wr_en = s1_valid_q && s1_wr_q;
  assign col_new   = s1_first_q ? s1_part_q : cwbd_pkg::sat_add(rd_data, s1_part_q);

  cwbd_colmem #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (AW),
    .DW    (SUMW)
  ) u_colmem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (bc_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (col_new)
  );

  // mean divider
  logic                div_start;
  logic                div_busy;
  logic                div_valid;
  logic                div_ready;
  cwbd_pkg::pix_item_t div_item;

  assign div_start = s1_valid_q && s1_out_q;

  cwbd_div #(
    .DIVW (DIVW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (s1_wr_q ? col_new : rd_data),
    .divisor_i (divisor),
    .flags_i   (s1_flags_q),
    .busy_o    (div_busy),
    .valid_o   (div_valid),
    .ready_i   (div_ready),
    .item_o    (div_item)
  );

  // pause input while a block mean is pending in the divider
  assign s_axis_tready = !(div_busy || div_start);

  // output register
  logic                out_valid_q;
  cwbd_pkg::pix_item_t out_item_q;

  assign div_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_valid && div_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid && div_ready) begin
      out_item_q <= div_item;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q.pixel;
  assign m_axis_tlast  = out_item_q.flags.row_end;
  assign m_axis_tuser  = out_item_q.flags.frame_end;

  // checks
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_en && mem_rd_en) |-> (s1_addr_q != bc_addr))
    else $error("column sum read and write-back hit the same entry");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_pixel_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_acc)
    else $error("pixel taken while a block mean is pending");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && div_ready) |=> m_axis_tvalid)
    else $error("divider result lost on the way to the output");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("frame end without row end");

endmodule

>>> test/tb_center_window_box_downsampler.sv
// ----------------------------------------------------------------------------
// tb_center_window_box_downsampler
// Streams source frames of green bytes into the downsampler and checks every
// emitted block pixel, with its row and frame end marks, against a predictor
// of the central-window mean kept in this bench. Covers the reset geometry,
// scale masking and clamping, width and height limits, flat and window-only
// images, output back-pressure and random whole frames under random stalls.
// ----------------------------------------------------------------------------
module tb_center_window_box_downsampler;

  localparam int MAX_OUT_WIDTH = 256;
  localparam int MAX_SCALE     = 64;
  localparam int PIX_MAX       = 255;
  localparam int SUM_CAP       = 2**cwbd_pkg::SUM_W - 1;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_GREENS = 800;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // index with no register behind it
  localparam logic [cwbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_FULL, FILL_WIN_HI, FILL_WIN_LO} fill_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;  // [7:0] green
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [7:0]                      m_axis_tdata;        // [7:0] pixel
  logic                            m_axis_tlast;        // row_end
  logic                            m_axis_tuser;        // [0] frame_end
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [cwbd_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [cwbd_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  center_window_box_downsampler #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_SCALE    (MAX_SCALE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int               col_sum [MAX_OUT_WIDTH];
  logic [5:0]       sub_col = '0;
  logic [5:0]       sub_row = '0;
  logic [7:0]       blk_col = '0;
  logic [7:0]       blk_row = '0;
  int               row_acc = 0;
  logic [cwbd_pkg::SCALE_W-1:0] scale_reg  = cwbd_pkg::RST_SCALE;
  logic [cwbd_pkg::DIM_W-1:0]   width_reg  = cwbd_pkg::RST_OUT_DIM;
  logic [cwbd_pkg::DIM_W-1:0]   height_reg = cwbd_pkg::RST_OUT_DIM;

  cwbd_pkg::pix_item_t expected_pix_q[$];
  cwbd_pkg::pix_item_t want;
  int        err_cnt    = 0;
  int        green_sent = 0;
  int        cycle_cnt  = 0;
  int        hold_req   = 0;
  int        rx_stall_left = 0;
  bit        tx_idle = 1'b0;
  bit        rx_idle = 1'b1;

  function automatic int eff_scale();
    int s;
    s = scale_reg & cwbd_pkg::SCALE_MASK;
    if (s < 4) s = 4;
    if (s > MAX_SCALE) s = MAX_SCALE;
    return s;
  endfunction

  function automatic int eff_dim(input logic [cwbd_pkg::DIM_W-1:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  // advance the block position by one source pixel; returns 1 on a block end
  function automatic bit box_step(input logic [7:0] g, output cwbd_pkg::pix_item_t res);
    int s, k, w, h, bc, d, mean;
    bit row_in, col_in, x_end, y_end, last_c, last_r;
    s      = eff_scale();
    k      = s / 4;
    w      = eff_dim(width_reg, MAX_OUT_WIDTH);
    h      = eff_dim(height_reg, int'(cwbd_pkg::MAX_OUT_HEIGHT));
    bc     = (blk_col < MAX_OUT_WIDTH) ? blk_col : MAX_OUT_WIDTH - 1;
    row_in = sub_row >= k && sub_row < s - k;
    col_in = sub_col >= k && sub_col < s - k;
    x_end  = sub_col >= s - 1;
    y_end  = sub_row >= s - 1;
    last_c = blk_col >= w - 1;
    last_r = blk_row >= h - 1;
    res    = '0;
    if (row_in && col_in) row_acc = (row_acc + g > SUM_CAP) ? SUM_CAP : row_acc + g;
    if (!x_end) begin
      sub_col++;
      return 1'b0;
    end
    if (row_in) begin
      if (sub_row == k) col_sum[bc] = row_acc;
      else col_sum[bc] = (col_sum[bc] + row_acc > SUM_CAP) ? SUM_CAP : col_sum[bc] + row_acc;
    end
    row_acc = 0;
    if (y_end) begin
      d    = (s / 2) * (s / 2);
      mean = col_sum[bc] / d;
      if (mean > PIX_MAX) mean = PIX_MAX;
      res.pixel           = 8'(PIX_MAX - mean);
      res.flags.row_end   = last_c;
      res.flags.frame_end = last_c && last_r;
    end
    sub_col = '0;
    if (last_c) begin
      blk_col = '0;
      if (y_end) begin
        sub_row = '0;
        blk_row = last_r ? 8'd0 : blk_row + 8'd1;
      end else begin
        sub_row = sub_row + 6'd1;
      end
    end else begin
      blk_col = blk_col + 8'd1;
    end
    return y_end;
  endfunction

  task automatic send_green(input logic [7:0] g);
    cwbd_pkg::pix_item_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= g;
    do @(posedge clk_i); while (!s_axis_tready);
    if (box_step(g, res)) expected_pix_q.push_back(res);
    green_sent++;
    if (tx_idle && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  // n_brows block rows of the current geometry, raster order
  task automatic send_rows(input int n_brows, input fill_e fill);
    int s, k, cols;
    bit in_win;
    logic [7:0] g;
    s    = eff_scale();
    k    = s / 4;
    cols = eff_dim(width_reg, MAX_OUT_WIDTH) * s;
    for (int y = 0; y < n_brows * s; y++) begin
      for (int x = 0; x < cols; x++) begin
        in_win = (x % s) >= k && (x % s) < s - k && (y % s) >= k && (y % s) < s - k;
        case (fill)
          FILL_ZERO:   g = 8'd0;
          FILL_FULL:   g = 8'd255;
          FILL_WIN_HI: g = in_win ? 8'd255 : 8'd0;
          FILL_WIN_LO: g = in_win ? 8'd0 : 8'd255;
          default:     g = 8'($urandom_range(0, 255));
        endcase
        send_green(g);
      end
    end
  endtask

  task automatic write_reg(input logic [cwbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cwbd_pkg::CFG_DATA_W-1:0] val,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cwbd_pkg::CFG_DISPLAY_SCALE: scale_reg  = val[cwbd_pkg::SCALE_W-1:0];
      cwbd_pkg::CFG_OUT_WIDTH:     width_reg  = val[cwbd_pkg::DIM_W-1:0];
      cwbd_pkg::CFG_OUT_HEIGHT:    height_reg = val[cwbd_pkg::DIM_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [cwbd_pkg::CFG_DATA_W-1:0] scale,
                              input logic [cwbd_pkg::CFG_DATA_W-1:0] w,
                              input logic [cwbd_pkg::CFG_DATA_W-1:0] h);
    write_reg(cwbd_pkg::CFG_DISPLAY_SCALE, scale, 1'b0);
    write_reg(cwbd_pkg::CFG_OUT_WIDTH, w, 1'b0);
    write_reg(cwbd_pkg::CFG_OUT_HEIGHT, h, 1'b1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_pix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one block row at the reset scale of 8 and the reset height of 64;
  // only the width is narrowed to two blocks
  task automatic test_reset_geometry();
    tx_idle = 1'b0;
    write_reg(cwbd_pkg::CFG_OUT_WIDTH, 9'd2, 1'b1);
    send_rows(1, FILL_RAND);
    wait_idle();
  endtask

  task automatic test_scale_codes();
    // zero scale clamps up to 4;
    // height 1 also realigns the block row left over from the reset geometry
    tx_idle = 1'b0;
    set_geometry(9'd0, 9'd1, 9'd1);
    send_rows(1, FILL_RAND);
    wait_idle();
    tx_idle = 1'b1;
    write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)), 1'b0);
    set_geometry(9'd3, 9'd1, 9'd1);
    send_rows(1, FILL_RAND);
    wait_idle();
    set_geometry(9'd7, 9'd1, 9'd1);
    send_rows(1, FILL_RAND);
    wait_idle();
    // masked low bits plus a bit above the register, scale 12
    set_geometry(9'd270, 9'd1, 9'd1);
    send_rows(1, FILL_RAND);
    wait_idle();
  endtask

  task automatic test_flat_levels();
    tx_idle = 1'b1;
    set_geometry(9'd4, 9'd2, 9'd1);
    send_rows(1, FILL_ZERO);
    send_rows(1, FILL_FULL);
    send_rows(1, FILL_WIN_HI);
    send_rows(1, FILL_WIN_LO);
    wait_idle();
  endtask

  task automatic test_dim_extremes();
    tx_idle = 1'b1;
    set_geometry(9'd4, 9'd0, 9'd2);
    send_rows(2, FILL_RAND);
    wait_idle();
    set_geometry(9'd4, 9'd1, 9'd0);
    send_rows(1, FILL_RAND);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_geometry(9'd4, 9'd4, 9'd2);
    hold_req = HOLD_CYCLES;
    send_rows(1, FILL_RAND);
    // sender pauses mid-frame until the output has caught up
    wait_idle();
    send_rows(1, FILL_RAND);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int s, w, h, pick, start;
    logic [cwbd_pkg::CFG_DATA_W-1:0] scale_val;
    fill_e fill;
    start = green_sent;
    while (green_sent < start + RANDOM_GREENS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        s = (pick < 12) ? 4 : (pick < 17) ? 8 : (pick < 19) ? 12 : 16;
        if (s == 4) begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 3);
        end else if (s == 8) begin
          w = $urandom_range(1, 4);
          h = $urandom_range(1, 2);
        end else begin
          w = $urandom_range(1, 2);
          h = 1;
        end
        // junk in the masked low bits and in the bits above the register
        scale_val = {2'($urandom_range(0, 3)), 5'(s >> 2), 2'($urandom_range(0, 3))};
        wait_idle();
        set_geometry(scale_val, 9'(w), 9'(h));
      end
      fill = ($urandom_range(0, 4) == 0) ? fill_e'($urandom_range(0, 4)) : FILL_RAND;
      send_rows(eff_dim(height_reg, int'(cwbd_pkg::MAX_OUT_HEIGHT)), fill);
    end
  endtask

  // output side: random stalls, plus long holds on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      rx_stall_left = hold_req;
      hold_req = 0;
    end
    if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle && $urandom_range(0, 99) < 25) rx_stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pix_q.size() == 0) begin
        $display("%0t: expected no result, got pixel %0d row_end %0b frame_end %0b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        err_cnt++;
      end else begin
        want = expected_pix_q.pop_front();
        if (m_axis_tdata !== want.pixel) begin
          $display("%0t: pixel expected %0d got %0d", $time, want.pixel, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== want.flags.row_end) begin
          $display("%0t: row_end expected %0b got %0b", $time, want.flags.row_end,
                   m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tuser !== want.flags.frame_end) begin
          $display("%0t: frame_end expected %0b got %0b", $time, want.flags.frame_end,
                   m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_scale_codes();
    test_flat_levels();
    test_dim_extremes();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (err_cnt == 0 && expected_pix_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
